// ===== rtl/core/pib_pkg.sv =====
// Shared constants and types for the palette index builder.
package pib_pkg;

   // Number of palette entries held by the colour table.
   localparam int PALETTE_SIZE = 256;

   // Derived widths: entry address and entry count (count can reach PALETTE_SIZE).
   localparam int ADDR_W  = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int CNT_W   = $clog2(PALETTE_SIZE + 1);

   // Fixed field widths of the stream payload.
   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int INDEX_W = 8;
   localparam int USED_W  = 9;

   // Write port into the colour table.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [COLOR_W-1:0] color;
   } pib_wr_type;

endpackage

// ===== rtl/core/palette_index_builder_top.sv =====
// Top level of the palette index builder: pixel stream in, palette index stream out.
//
// Usage:
//   The request channel (req_) carries one RGB pixel per transaction, red in the
//   lowest byte of req_tdata, and req_tuser set on the first pixel of an image,
//   which empties the colour table before that pixel is looked up.
//   The response channel (rsp_) returns one transaction per pixel, in order: the
//   palette index and the number of entries in use in rsp_tdata, the new-entry
//   and overflow flags in rsp_tuser.
//   A pixel passes through the stage-one register, the stage-two match register
//   and the output register before its result is valid.
//   Throughput is one pixel per cycle while the receiver takes results, set by
//   the single registered compare of the pixel against all table entries at once.
//   Colours get indices in order of first appearance; once the table is full an
//   unseen colour maps to index 0 with overflow set and is not stored.
//   Reset empties the table and clears all pipeline valids; no sweep is needed.
//   When the receiver stalls, the output register holds its result and the two
//   internal stages keep filling, so req_tready falls only once all are full.
module palette_index_builder_top (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tuser,   // image_start [0]
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // palette_index [7:0], colors_used [16:8], zero [23:17]
   output logic [1:0]  rsp_tuser    // new_entry [0], overflow [1]
);
   import pib_pkg::*;

   // Stage one: registered pixel.
   logic                s1_valid_ff, s1_valid_in;
   logic [COLOR_W-1:0]  s1_color_ff;
   logic                s1_start_ff;

   // Stage two: registered match vector and its pixel.
   logic                s2_valid_ff, s2_valid_in;
   logic [COLOR_W-1:0]  s2_color_ff;
   logic                s2_start_ff;
   logic [PALETTE_SIZE-1:0] match_ff;

   // Output register.
   logic                out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0]  out_index_ff;
   logic [USED_W-1:0]   out_used_ff;
   logic                out_new_ff;
   logic                out_over_ff;

   // Entry count.
   logic [CNT_W-1:0]    count_ff, count_in;

   // Flow control.
   logic                out_load;
   logic                s2_load;
   logic                s1_load;
   logic                s2_fire;

   // Resolve logic.
   logic [CNT_W-1:0]    base_count;
   logic                hit;
   logic [ADDR_W-1:0]   hit_idx;
   logic                full;
   logic                append;
   logic [ADDR_W-1:0]   res_idx;
   pib_wr_type          wr;

   // Each stage loads when it is empty or its contents move on this cycle.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign s2_load    = !s2_valid_ff || out_load;
   assign s1_load    = !s1_valid_ff || s2_load;
   assign s2_fire    = s2_valid_ff && out_load;
   assign req_tready = s1_load;

   assign s1_valid_in  = s1_load ? req_tvalid : s1_valid_ff;
   assign s2_valid_in  = s2_load ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_load ? s2_valid_ff : out_valid_ff;

   // Valid bits and entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_color_ff <= {req_tdata[2*CHAN_W +: CHAN_W],
                         req_tdata[CHAN_W +: CHAN_W],
                         req_tdata[0 +: CHAN_W]};
         s1_start_ff <= req_tuser;
      end
   end

   // Stage two payload travels beside the match vector.
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_color_ff <= s1_color_ff;
         s2_start_ff <= s1_start_ff;
      end
   end

   // Colour table and compare.
   pib_color_cam u_cam (
      .clock     (clock),
      .wr        (wr),
      .cmp_en    (s2_load),
      .cmp_color (s1_color_ff),
      .match_ff  (match_ff)
   );

   // Only entries below the count take part; an image start empties the table.
   assign base_count = s2_start_ff ? '0 : count_ff;

   // Table colours are distinct, so at most one lane can hit: OR the indices.
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         if (match_ff[i] && (CNT_W'(i) < base_count)) begin
            hit     = 1'b1;
            hit_idx = hit_idx | ADDR_W'(i);
         end
      end
   end

   // Append an unseen colour while there is room.
   assign full   = (base_count == CNT_W'(PALETTE_SIZE));
   assign append = !hit && !full;

   always_comb begin
      if (hit) begin
         res_idx = hit_idx;
      end else if (append) begin
         res_idx = ADDR_W'(base_count);
      end else begin
         res_idx = '0;
      end
   end

   assign wr.en    = s2_fire && append;
   assign wr.addr  = ADDR_W'(base_count);
   assign wr.color = s2_color_ff;

   // Count moves only when a transaction is resolved.
   always_comb begin
      count_in = count_ff;
      if (s2_fire) begin
         count_in = base_count + CNT_W'(append);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (s2_fire) begin
         out_index_ff <= INDEX_W'(res_idx);
         out_used_ff  <= USED_W'(base_count + CNT_W'(append));
         out_new_ff   <= append;
         out_over_ff  <= !hit && full;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(24 - INDEX_W - USED_W){1'b0}}, out_used_ff, out_index_ff};
   assign rsp_tuser  = {out_over_ff, out_new_ff};

endmodule

// ===== rtl/core/pib_color_cam.sv =====
// Colour table cells with a parallel compare against every entry.
module pib_color_cam (
   input  logic                          clock,
   input  pib_pkg::pib_wr_type           wr,
   input  logic                          cmp_en,
   input  logic [pib_pkg::COLOR_W-1:0]   cmp_color,
   output logic [pib_pkg::PALETTE_SIZE-1:0] match_ff
);
   import pib_pkg::*;

   logic [COLOR_W-1:0]      cell_ff [PALETTE_SIZE];
   logic [PALETTE_SIZE-1:0] match_in;

   // Cell storage: one entry written per transaction that adds a colour.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         cell_ff[wr.addr] <= wr.color;
      end
   end

   // Each lane compares against the value its cell holds after this edge, so a
   // colour being written now is seen by the pixel following straight behind.
   always_comb begin
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         if (wr.en && (wr.addr == ADDR_W'(i))) begin
            match_in[i] = (wr.color == cmp_color);
         end else begin
            match_in[i] = (cell_ff[i] == cmp_color);
         end
      end
   end

   // Registered match vector.
   always_ff @(posedge clock) begin
      if (cmp_en) begin
         match_ff <= match_in;
      end
   end

endmodule

// ===== dv/palette_index_builder_top_tb.sv =====
// Self-checking testbench for the palette index builder: pixel stream in, palette index stream out.
`timescale 1ns / 1ps

module palette_index_builder_top_tb;
   import pib_pkg::*;

   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int TARGET_PIXELS  = 550;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 64;
   localparam int BIG_POOL       = 280;
   localparam int BIG_IMAGE      = 300;
   localparam int TIMEOUT_NS     = 5_000_000;

   // One result as the block reports it.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               new_entry;
      logic               overflow;
      logic [USED_W-1:0]  used;
   } pixel_result_type;

   // One directed pixel; the result is typed in only where 'typed' is set.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              start;
      logic              typed;
      pixel_result_type  result;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 18;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // red [7:0], green [15:8], blue [23:16]
   logic        req_tuser  = 1'b0; // image_start [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // palette_index [7:0], colors_used [16:8], zero [23:17]
   logic [1:0]  rsp_tuser;         // new_entry [0], overflow [1]

   // Predicted colour table and the results still owed by the block.
   logic [COLOR_W-1:0] colour_table [PALETTE_SIZE];
   int                 entries_in_use = 0;
   pixel_result_type   pending_indices [$];
   int                 pixels_sent = 0;
   int                 mismatches  = 0;

   // Directed stimulus: extremes, seen colours, image restarts.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd2}},
      '{8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd2, 1'b1, 1'b0, 9'd3}},
      '{8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, '{8'd3, 1'b1, 1'b0, 9'd4}},
      '{8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, '{8'd4, 1'b1, 1'b0, 9'd5}},
      '{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, '{8'd1, 1'b0, 1'b0, 9'd5}},
      '{8'h01, 8'h02, 8'h03, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0, 9'd0}},
      '{8'h80, 8'h40, 8'h20, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0, 9'd0}},
      '{8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0, 9'd0}},
      '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
      '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
      '{8'h12, 8'h34, 8'h56, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
      '{8'hAA, 8'h55, 8'hAA, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
      '{8'h55, 8'hAA, 8'h55, 1'b0, 1'b1, '{8'd2, 1'b1, 1'b0, 9'd3}},
      '{8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
      '{8'hFE, 8'hFF, 8'hFF, 1'b0, 1'b0, '{8'd0, 1'b0, 1'b0, 9'd0}}
   };

   palette_index_builder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int random_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // Looks a pixel up in the predicted table and updates it as the block should.
   task automatic predict_index(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                                input logic [CHAN_W-1:0] blue, input logic start,
                                output pixel_result_type res);
      logic [COLOR_W-1:0] colour;
      int                 hit;
      colour = {red, green, blue};
      hit    = -1;
      res    = '0;
      if (start) entries_in_use = 0;
      for (int i = 0; i < entries_in_use; i++) begin
         if (hit < 0 && colour_table[i] == colour) hit = i;
      end
      if (hit >= 0) begin
         res.index = INDEX_W'(hit);
      end else if (entries_in_use < PALETTE_SIZE) begin
         res.index                    = INDEX_W'(entries_in_use);
         colour_table[entries_in_use] = colour;
         entries_in_use++;
         res.new_entry = 1'b1;
      end else begin
         res.overflow = 1'b1;
      end
      res.used = USED_W'(entries_in_use);
   endtask

   // Offers one pixel until the block takes it, then records the result it owes.
   task automatic send_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                             input logic [CHAN_W-1:0] blue, input logic start, input logic typed,
                             input pixel_result_type typed_result, input int gap);
      pixel_result_type predicted;
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_index(red, green, blue, start, predicted);
      pending_indices.push_back(typed ? typed_result : predicted);
      pixels_sent++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits for every owed result.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_indices.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Receiver: checks each transaction and stalls at random, with long hold-offs after the 40th and 420th results.
   initial begin : response_side
      int               hold_left;
      int               results_seen;
      pixel_result_type want;
      hold_left    = 0;
      results_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_indices.size() == 0) begin
               $display("%0t: result with no pixel outstanding, actual index %0d", $time,
                        rsp_tdata[7:0]);
               mismatches++;
            end else begin
               want = pending_indices.pop_front();
               compare_field("palette_index", want.index, rsp_tdata[7:0]);
               compare_field("colors_used", want.used, rsp_tdata[16:8]);
               compare_field("new_entry", want.new_entry, rsp_tuser[0]);
               compare_field("overflow", want.overflow, rsp_tuser[1]);
            end
            results_seen++;
            if (results_seen == 40 || results_seen == 420) hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= 1'b1;
            // A stretch of results is taken with no stall at all.
            if (results_seen < 100 || results_seen >= 200) hold_left = random_gap();
         end
      end
   end

   // Sender: directed table, one image that overflows the table, then many small images.
   initial begin : pixel_source
      directed_row_type   row;
      logic [COLOR_W-1:0] colour_pool [$];
      logic [COLOR_W-1:0] colour;
      int                 pool_size;
      int                 image_len;
      logic               burst;
      logic               start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_pixel(row.red, row.green, row.blue, row.start, row.typed, row.result, random_gap());
      end
      drain_results();

      // Distinct colours past the table size, then revisits of stored and rejected ones.
      for (int i = 0; i < BIG_POOL; i++) colour_pool.push_back({15'($urandom), 9'(i)});
      for (int i = 0; i < BIG_IMAGE; i++) begin
         if (i < BIG_POOL) colour = colour_pool[i];
         else if (i == BIG_POOL) colour = colour_pool[PALETTE_SIZE-1];
         else colour = colour_pool[$urandom_range(0, BIG_POOL-1)];
         send_pixel(colour[23:16], colour[15:8], colour[7:0], i == 0, 1'b0, '0,
                    (i >= 100 && i < 160) ? 0 : random_gap());
      end
      drain_results();

      // Small images drawn from small colour sets, with some noise pixels and stray restarts.
      while (pixels_sent < TARGET_PIXELS) begin
         pool_size = $urandom_range(1, 16);
         image_len = $urandom_range(1, 40);
         burst     = ($urandom_range(0, 4) == 0);
         colour_pool.delete();
         repeat (pool_size) colour_pool.push_back(COLOR_W'($urandom));
         for (int n = 0; n < image_len; n++) begin
            if ($urandom_range(0, 99) < 8) colour = COLOR_W'($urandom);
            else colour = colour_pool[$urandom_range(0, pool_size-1)];
            start = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
            send_pixel(colour[23:16], colour[15:8], colour[7:0], start, 1'b0, '0,
                       burst ? 0 : random_gap());
         end
         if ($urandom_range(0, 5) == 0) drain_results();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("palette_index_builder_top_tb passed");
      end else begin
         $display("palette_index_builder_top_tb failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("palette_index_builder_top_tb failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pib_pkg.sv
rtl/core/pib_color_cam.sv
rtl/core/palette_index_builder_top.sv
dv/palette_index_builder_top_tb.sv
